FILE: rtl/core/tnb_pkg.sv
// Shared constants and types for the triangle normal and bounding box block.
`timescale 1ns / 1ps
`default_nettype none
package tnb_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int NRM_BITS = 16;
    localparam int MAG_BITS = 30;
    localparam int LEN2_BITS = 62;
    localparam int LEN_BITS = 31;
    localparam int QUO_BITS = 17;

    typedef enum logic [0:0] {
        CMD_PROCESS = 1'b0,
        CMD_CLEAR   = 1'b1
    } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/tnb_front.sv
// Front end: edge vectors, bounding box update and queue of work for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tnb_front #(
    parameter int COORD_BITS = tnb_pkg::COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         in_cmd,
    input  wire logic [9*COORD_BITS-1:0]      in_vtx,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output logic [6*(COORD_BITS+1)-1:0]       q_edges,
    output logic [6*COORD_BITS-1:0]           q_box
);
    import tnb_pkg::*;
    localparam int EB = COORD_BITS + 1;
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] min_reg [3];
    logic signed [COORD_BITS-1:0] max_reg [3];
    logic signed [COORD_BITS-1:0] min_next [3];
    logic signed [COORD_BITS-1:0] max_next [3];
    logic signed [COORD_BITS-1:0] v [3][3];
    logic [6*EB-1:0] edges_next;
    logic [6*COORD_BITS-1:0] box_next;

    // two-entry queue
    logic [6*EB-1:0]          qe_reg [2];
    logic [6*COORD_BITS-1:0]  qb_reg [2];
    logic                     wp_reg, rp_reg;
    logic [1:0]               cnt_reg;
    logic                     push, pop;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                v[j][k] = in_vtx[(3*j+k)*COORD_BITS +: COORD_BITS];
            end
        end
        for (int k = 0; k < 3; k++) begin
            min_next[k] = min_reg[k];
            max_next[k] = max_reg[k];
            for (int j = 0; j < 3; j++) begin
                if (v[j][k] < min_next[k]) min_next[k] = v[j][k];
                if (v[j][k] > max_next[k]) max_next[k] = v[j][k];
            end
            edges_next[k*EB +: EB]     = EB'({v[1][k][COORD_BITS-1], v[1][k]}
                                             - {v[0][k][COORD_BITS-1], v[0][k]});
            edges_next[(3+k)*EB +: EB] = EB'({v[2][k][COORD_BITS-1], v[2][k]}
                                             - {v[0][k][COORD_BITS-1], v[0][k]});
            box_next[k*COORD_BITS +: COORD_BITS]     = min_next[k];
            box_next[(3+k)*COORD_BITS +: COORD_BITS] = max_next[k];
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_cmd == CMD_PROCESS);
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_edges  = qe_reg[rp_reg];
    assign q_box    = qb_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
            for (int k = 0; k < 3; k++) begin
                min_reg[k] <= CMAX;
                max_reg[k] <= CMIN;
            end
        end else begin
            if (in_valid && in_ready) begin
                for (int k = 0; k < 3; k++) begin
                    min_reg[k] <= (in_cmd == CMD_CLEAR) ? CMAX : min_next[k];
                    max_reg[k] <= (in_cmd == CMD_CLEAR) ? CMIN : max_next[k];
                end
            end
            if (push) begin
                qe_reg[wp_reg] <= edges_next;
                qb_reg[wp_reg] <= box_next;
                wp_reg <= ~wp_reg;
            end
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/tnb_back.sv
// Back end: cross product, scaling, square root and divisions, then output register.
`timescale 1ns / 1ps
`default_nettype none
module tnb_back #(
    parameter int COORD_BITS = tnb_pkg::COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire logic [6*(COORD_BITS+1)-1:0]  q_edges,
    input  wire logic [6*COORD_BITS-1:0]      q_box,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [3*tnb_pkg::NRM_BITS-1:0]    out_nrm,
    output logic [3*tnb_pkg::NRM_BITS-1:0]    out_col,
    output logic [6*COORD_BITS-1:0]           out_box
);
    import tnb_pkg::*;
    localparam int EB = COORD_BITS + 1;
    localparam int PB = 2*EB;
    localparam int CB = PB + 1;
    localparam int BLW = $clog2(CB + 1);
    localparam int NB = MAG_BITS + 16 + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SUB  = 8'b0000_0100,
        S_SCL  = 8'b0000_1000,
        S_SQ   = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } st_t;

    st_t st_reg;
    logic [1:0] k_reg;
    logic [5:0] it_reg;
    logic [6*EB-1:0]       ed_reg;
    logic signed [EB-1:0]  e1 [3];
    logic signed [EB-1:0]  e2 [3];
    logic signed [PB-1:0]  pa_reg, pb_reg;
    logic [CB-1:0]         cm_reg [3];
    logic                  neg_reg [3];
    logic [MAG_BITS-1:0]   m_reg [3];
    logic [BLW-1:0]        sh_reg;
    logic [LEN2_BITS-1:0]  l2_reg, x_reg, rr_reg, bit_reg;
    logic [LEN_BITS-1:0]   len_reg;
    logic [NB-1:0]         num_reg, rem_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    logic [NRM_BITS-1:0]   nrm_reg [3];
    logic signed [EB-1:0]  pq, pr, ps, pt;
    logic signed [CB-1:0]  diff;
    logic [CB-1:0]         orv;
    logic [BLW-1:0]        blen;
    logic [2*MAG_BITS-1:0] sq;
    logic [NB-1:0]         dr;
    logic [NB:0]           dt;

    assign q_ready = (st_reg == S_IDLE) && !out_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = ed_reg[k*EB +: EB];
            e2[k] = ed_reg[(3+k)*EB +: EB];
        end
        case (k_reg)
            2'd0:    begin pq = e2[1]; pr = e1[2]; ps = e2[2]; pt = e1[1]; end
            2'd1:    begin pq = e2[2]; pr = e1[0]; ps = e2[0]; pt = e1[2]; end
            default: begin pq = e2[0]; pr = e1[1]; ps = e2[1]; pt = e1[0]; end
        endcase
        diff = {pa_reg[PB-1], pa_reg} - {pb_reg[PB-1], pb_reg};
        orv = cm_reg[0] | cm_reg[1] | cm_reg[2];
        blen = '0;
        for (int i = 0; i < CB; i++) begin
            if (orv[i]) blen = BLW'(i + 1);
        end
        sq = m_reg[k_reg] * m_reg[k_reg];
        dr = {rem_reg[NB-2:0], num_reg[NB-1]};
        dt = {1'b0, dr} - {1'b0, NB'({len_reg, 1'b0})};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            out_valid <= 1'b0;
            k_reg     <= 2'd0;
            it_reg    <= '0;
        end else begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        ed_reg  <= q_edges;
                        out_box <= q_box;
                        k_reg   <= 2'd0;
                        st_reg  <= S_MUL;
                    end
                end
                S_MUL: begin
                    pa_reg <= pq * pr;
                    pb_reg <= ps * pt;
                    st_reg <= S_SUB;
                end
                S_SUB: begin
                    neg_reg[k_reg] <= diff[CB-1];
                    cm_reg[k_reg]  <= diff[CB-1] ? CB'(-diff) : CB'(diff);
                    if (k_reg == 2'd2) begin
                        st_reg <= S_SCL;
                    end else begin
                        k_reg  <= k_reg + 2'd1;
                        st_reg <= S_MUL;
                    end
                end
                S_SCL: begin
                    sh_reg <= (blen > BLW'(MAG_BITS)) ? blen - BLW'(MAG_BITS) : '0;
                    k_reg  <= 2'd0;
                    l2_reg <= '0;
                    st_reg <= S_SQ;
                end
                S_SQ: begin
                    // one component at a time: shift then square-accumulate
                    m_reg[k_reg] <= MAG_BITS'(cm_reg[k_reg] >> sh_reg);
                    if (it_reg[0]) begin
                        l2_reg <= l2_reg + LEN2_BITS'(sq);
                        it_reg <= '0;
                        if (k_reg == 2'd2) begin
                            x_reg   <= l2_reg + LEN2_BITS'(sq);
                            rr_reg  <= '0;
                            bit_reg <= LEN2_BITS'(1) << (LEN2_BITS - 2);
                            st_reg  <= S_SQRT;
                        end else begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end else begin
                        it_reg <= 6'd1;
                    end
                end
                S_SQRT: begin
                    if (bit_reg == '0) begin
                        len_reg <= LEN_BITS'(rr_reg);
                        k_reg   <= 2'd0;
                        it_reg  <= '0;
                        st_reg  <= S_DIV;
                    end else begin
                        if (x_reg >= rr_reg + bit_reg) begin
                            x_reg  <= x_reg - (rr_reg + bit_reg);
                            rr_reg <= (rr_reg >> 1) + bit_reg;
                        end else begin
                            rr_reg <= rr_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIV: begin
                    // restoring division of (m<<16)+len by 2*len, one bit a cycle
                    if (it_reg == 6'd0) begin
                        num_reg <= NB'({m_reg[k_reg], 16'd0}) + NB'(len_reg);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        it_reg  <= 6'd1;
                    end else if (it_reg <= 6'(NB)) begin
                        num_reg <= num_reg << 1;
                        if (!dt[NB]) begin
                            rem_reg <= dt[NB-1:0];
                            quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
                        end else begin
                            rem_reg <= dr;
                            quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
                        end
                        it_reg <= it_reg + 6'd1;
                    end else begin
                        if (len_reg == '0) begin
                            nrm_reg[k_reg] <= '0;
                        end else if (neg_reg[k_reg]) begin
                            nrm_reg[k_reg] <= (quo_reg > QUO_BITS'(32768)) ? 16'h8000
                                              : NRM_BITS'(-quo_reg);
                        end else begin
                            nrm_reg[k_reg] <= (quo_reg > QUO_BITS'(32767)) ? 16'h7fff
                                              : NRM_BITS'(quo_reg);
                        end
                        it_reg <= '0;
                        if (k_reg == 2'd2) st_reg <= S_OUT;
                        else k_reg <= k_reg + 2'd1;
                    end
                end
                S_OUT: begin
                    for (int k = 0; k < 3; k++) begin
                        out_nrm[k*NRM_BITS +: NRM_BITS] <= nrm_reg[k];
                        out_col[k*NRM_BITS +: NRM_BITS] <= nrm_reg[k] ^ 16'h8000;
                    end
                    out_valid <= 1'b1;
                    st_reg    <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/triangle_normal_bbox_top.sv
// Top level of the triangle face normal and running bounding box block.
//  channel | dir | tdata fields (low bit first)
//  s_      | in  | tuser: command; tdata: vertex0_x..vertex2_z
//  m_      | out | tdata: normal_x/y/z, color_red/green/blue, box_min_x..z, box_max_x..z
// A triangle passes through the bit-serial square root and three serial divisions in the
// back end. The back end waits for its result to be taken.
// Reset (aresetn low, synchronous) empties the queue and sets the box to its empty value.
// The front keeps taking beats while the two-entry queue has room.
`timescale 1ns / 1ps
`default_nettype none
module triangle_normal_bbox_top #(
    parameter int COORD_BITS = tnb_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [0:0]              s_tuser,   // command
    input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata, // v0 x,y,z, v1 x,y,z, v2 x,y,z
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // normal x,y,z, colour r,g,b, min x,y,z, max x,y,z
    output logic [((96+6*COORD_BITS+7)/8)*8-1:0] m_tdata
);
    import tnb_pkg::*;
    localparam int EB = COORD_BITS + 1;
    localparam int OW = ((96 + 6*COORD_BITS + 7)/8)*8;

    logic                    q_valid, q_ready;
    logic [6*EB-1:0]         q_edges;
    logic [6*COORD_BITS-1:0] q_box, o_box;
    logic [3*NRM_BITS-1:0]   o_nrm, o_col;

    tnb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(s_tuser[0]),
        .in_vtx(s_tdata[9*COORD_BITS-1:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_edges(q_edges), .q_box(q_box)
    );

    tnb_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_edges(q_edges), .q_box(q_box),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_nrm(o_nrm), .out_col(o_col), .out_box(o_box)
    );

    assign m_tdata = OW'({o_box, o_col, o_nrm});
endmodule
`default_nettype wire
